// File: src/tooth_period_rpm_meter_macros.svh
// Assertion shorthands shared by the meter's modules.
// They sample on i_clk and stay quiet while i_rst_n is low.
`ifndef TOOTH_PERIOD_RPM_METER_MACROS_SVH
`define TOOTH_PERIOD_RPM_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TPRM_CHECK_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tprm: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TPRM_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tprm: next-cycle check failed");

`endif

// File: src/tprm_pkg.sv
`default_nettype none

package tprm_pkg;

    // Ring of stored tooth-edge timestamps.
    localparam int RING_DEPTH = 16;
    localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int FILL_W     = $clog2(RING_DEPTH + 1);
    localparam int CNT_W      = SLOT_W;

    // Field widths.
    localparam int TIME_W  = 48;
    localparam int GAP_W   = 32;
    localparam int TEETH_W = 16;
    localparam int RPM_W   = 32;
    localparam int CFG_W   = 32;

    // Sum of up to RING_DEPTH-1 gaps, each below 2^32.
    localparam int SUM_W  = GAP_W + CNT_W;
    // Divisor is sum times teeth per revolution.
    localparam int DEN_W  = SUM_W + TEETH_W;
    // 60 s * 1e6 us * 256 fractional steps, below 2^34.
    localparam int SCALE_W = 34;
    localparam longint unsigned RPM_SCALE = 64'd15360000000;
    localparam int NUM_W  = SCALE_W + CNT_W;
    localparam int DIVC_W = $clog2(NUM_W);

    // Register reset values.
    localparam logic [TEETH_W-1:0] TEETH_RESET   = 16'd1;
    localparam logic [GAP_W-1:0]   MAX_GAP_RESET = 32'd1000000;

    // Configuration register indexes.
    localparam logic CFG_TEETH   = 1'b0;
    localparam logic CFG_MAX_GAP = 1'b1;

    // Request function codes.
    typedef enum logic [1:0] {
        FUNC_EDGE    = 2'd0,
        FUNC_COMPUTE = 2'd1,
        FUNC_TIMEOUT = 2'd2
    } t_func;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CUT,
        S_DIV,
        S_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic do_edge;
        logic do_timeout;
        logic zero_out;
        logic walk_load;
        logic walk_run;
        logic cut;
        logic div_step;
        logic div_done;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic fill_ge2;
        logic walk_done;
        logic no_pass;
        logic div_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// File: src/tprm_ctrl.sv
`default_nettype none

module tprm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    input  wire logic [1:0]       i_func,
    input  wire tprm_pkg::t_dp_sts i_sts,
    output logic                  busy,
    output tprm_pkg::t_dp_cmd     o_cmd
);
    import tprm_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (t_func'(i_func))
                        FUNC_EDGE: begin
                            o_cmd.do_edge = 1'b1;
                        end
                        FUNC_COMPUTE: begin
                            if (i_sts.fill_ge2) begin
                                o_cmd.walk_load = 1'b1;
                                n_state         = S_WALK;
                            end else begin
                                o_cmd.zero_out = 1'b1;
                            end
                        end
                        FUNC_TIMEOUT: begin
                            o_cmd.do_timeout = 1'b1;
                        end
                        default: begin
                            o_cmd.zero_out = 1'b1;
                        end
                    endcase
                end
            end
            S_WALK: begin
                o_cmd.walk_run = 1'b1;
                if (i_sts.walk_done) begin
                    n_state = S_CUT;
                end
            end
            S_CUT: begin
                // The ring is cut back here; with no passing gap the request ends.
                o_cmd.cut = 1'b1;
                if (i_sts.no_pass) begin
                    o_cmd.zero_out = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.div_done = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

// File: src/tprm_dp.sv
`default_nettype none

`include "tooth_period_rpm_meter_macros.svh"

module tprm_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire tprm_pkg::t_dp_cmd i_cmd,
    output tprm_pkg::t_dp_sts  o_sts,
    input  wire logic [47:0]   i_now_us,
    input  wire logic          i_cfg_we,
    input  wire logic          i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    output logic               o_strobe,
    output logic [31:0]        o_rpm_x256,
    output logic               o_edge_seen
);
    import tprm_pkg::*;

    // Configuration registers.
    logic [TEETH_W-1:0] r_teeth;
    logic [GAP_W-1:0]   r_max_gap;

    // Architectural state.
    logic [TIME_W-1:0]  r_ring [RING_DEPTH];
    logic [SLOT_W-1:0]  r_write_slot;
    logic [FILL_W-1:0]  r_fill;
    logic [TIME_W-1:0]  r_last_edge;
    logic [RPM_W-1:0]   r_held;

    // Ring walk.
    logic [SLOT_W-1:0]  r_rd_addr;
    logic [FILL_W-1:0]  r_left;
    logic               r_pend;
    logic [TIME_W-1:0]  r_rdata;
    logic [TIME_W-1:0]  r_newer;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_count;

    // Divider.
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [NUM_W-1:0]   r_quo;
    logic [DIVC_W-1:0]  r_div_cnt;

    // Result register.
    logic               r_out_valid;
    logic [RPM_W-1:0]   r_out_rpm;
    logic               r_out_edge;

    logic [SLOT_W:0]    start_sum;
    logic [SLOT_W-1:0]  start_addr;
    logic [SLOT_W-1:0]  addr_dec;
    logic [SLOT_W-1:0]  slot_inc;
    logic               rd_en;
    logic [TIME_W-1:0]  gap;
    logic               gap_pass;
    logic [TIME_W-1:0]  idle_time;
    logic               timed_out;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic [TIME_W-1:0]  mem_wdata;
    logic [DEN_W:0]     rem_sh;
    logic [DEN_W:0]     rem_diff;
    logic               q_bit;
    logic [RPM_W-1:0]   rpm_sat;
    logic [3:0]         finish_vec;
    logic               finishing;
    logic               single_stamp;

    // Ring address arithmetic, modulo the ring depth.
    always_comb begin
        start_sum  = {1'b0, r_write_slot} + (SLOT_W + 1)'(RING_DEPTH - 2);
        start_addr = (start_sum >= (SLOT_W + 1)'(RING_DEPTH))
                     ? SLOT_W'(start_sum - (SLOT_W + 1)'(RING_DEPTH))
                     : SLOT_W'(start_sum);
        addr_dec   = (r_rd_addr == '0) ? SLOT_W'(RING_DEPTH - 1) : r_rd_addr - 1'b1;
        slot_inc   = (r_write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : r_write_slot + 1'b1;
    end

    // Gap between the newer stamp and the one just read; times wrap modulo 2^48.
    assign rd_en     = i_cmd.walk_run && (r_left != '0);
    assign gap       = r_newer - r_rdata;
    assign gap_pass  = (gap < {{(TIME_W - GAP_W){1'b0}}, r_max_gap});
    assign idle_time = i_now_us - r_last_edge;
    assign timed_out = (idle_time > {{(TIME_W - GAP_W){1'b0}}, r_max_gap});

    // An edge writes its stamp; the cut moves the newest stamp to slot zero.
    assign mem_we    = i_cmd.do_edge || i_cmd.cut;
    assign mem_waddr = i_cmd.cut ? '0 : r_write_slot;
    assign mem_wdata = i_cmd.cut ? r_last_edge : i_now_us;

    // Stamp memory with registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_ring[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            r_rdata <= r_ring[r_rd_addr];
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_teeth   <= TEETH_RESET;
            r_max_gap <= MAX_GAP_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TEETH:   r_teeth   <= i_cfg_data[TEETH_W-1:0];
                CFG_MAX_GAP: r_max_gap <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Ring pointer, fill count and last edge time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_slot <= '0;
            r_fill       <= '0;
            r_last_edge  <= '0;
        end else if (i_cmd.do_edge) begin
            r_write_slot <= slot_inc;
            if (r_fill != FILL_W'(RING_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
            r_last_edge <= i_now_us;
        end else if (i_cmd.cut) begin
            r_write_slot <= SLOT_W'(1 % RING_DEPTH);
            r_fill       <= FILL_W'(1);
        end
    end

    // Walk from the newest stamp back, summing the gaps that pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.walk_load) begin
            r_left <= r_fill - 1'b1;
            r_pend <= 1'b0;
        end else if (i_cmd.walk_run) begin
            r_pend <= (r_left != '0);
            if (r_left != '0) begin
                r_left <= r_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.walk_load) begin
            r_rd_addr <= start_addr;
            r_newer   <= r_last_edge;
            r_sum     <= '0;
            r_count   <= '0;
        end else if (i_cmd.walk_run) begin
            if (r_left != '0) begin
                r_rd_addr <= addr_dec;
            end
            if (r_pend) begin
                r_newer <= r_rdata;
                if (gap_pass) begin
                    r_sum   <= r_sum + SUM_W'(gap[GAP_W-1:0]);
                    r_count <= r_count + 1'b1;
                end
            end
        end
    end

    // Restoring divider step: one quotient bit per cycle.
    always_comb begin
        rem_sh   = {r_rem, r_num[NUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        q_bit    = ~rem_diff[DEN_W];
    end

    // A zero divisor yields an all-ones quotient, which saturates below.
    always_ff @(posedge i_clk) begin
        if (i_cmd.cut) begin
            r_num <= NUM_W'(RPM_SCALE) * NUM_W'(r_count);
            r_den <= DEN_W'(r_sum) * DEN_W'(r_teeth);
            r_rem <= '0;
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_num <= {r_num[NUM_W-2:0], 1'b0};
            r_rem <= q_bit ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.cut) begin
            r_div_cnt <= DIVC_W'(NUM_W - 1);
        end else if (i_cmd.div_step && (r_div_cnt != '0)) begin
            r_div_cnt <= r_div_cnt - 1'b1;
        end
    end

    assign rpm_sat = (|r_quo[NUM_W-1:RPM_W]) ? '1 : r_quo[RPM_W-1:0];

    // Commands that end a request and so produce a result.
    assign finish_vec = {i_cmd.do_edge, i_cmd.do_timeout, i_cmd.zero_out, i_cmd.div_done};
    assign finishing  = |finish_vec;

    // Held speed and the one-cycle result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= finishing;
            if (i_cmd.div_done) begin
                r_held <= rpm_sat;
            end else if (i_cmd.do_timeout && timed_out) begin
                r_held <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_edge <= i_cmd.do_edge;
        if (i_cmd.div_done) begin
            r_out_rpm <= rpm_sat;
        end else if (i_cmd.do_timeout) begin
            r_out_rpm <= timed_out ? '0 : r_held;
        end else begin
            r_out_rpm <= '0;
        end
    end

    // Status to the controller.
    always_comb begin
        o_sts.fill_ge2  = (r_fill >= FILL_W'(2));
        o_sts.walk_done = (r_left == '0) && !r_pend;
        o_sts.no_pass   = (r_count == '0);
        o_sts.div_last  = (r_div_cnt == '0);
    end

    assign o_strobe    = r_out_valid;
    assign o_rpm_x256  = r_out_rpm;
    assign o_edge_seen = r_out_edge;

    // Only the newest stamp is left, in slot zero.
    assign single_stamp = (r_fill == FILL_W'(1)) && (r_write_slot == SLOT_W'(1 % RING_DEPTH));

    // Every finishing command produces exactly one strobe in the next cycle.
    `TPRM_CHECK_NEXT(a_result_follows, finishing, r_out_valid)
    // At most one finishing command is issued at a time.
    `TPRM_CHECK_NOW(a_one_finisher, 1'b1, $onehot0(finish_vec))
    // The fill count never passes the ring depth.
    `TPRM_CHECK_NOW(a_fill_bounded, 1'b1, r_fill <= FILL_W'(RING_DEPTH))
    // After a cut only the newest stamp remains, in slot zero.
    `TPRM_CHECK_NEXT(a_cut_keeps_one, i_cmd.cut, single_stamp)

endmodule

`default_nettype wire

// File: src/tooth_period_rpm_meter.sv
// Tooth edge, timeout check, undefined select and compute with fewer than two stamps: strobe
// in the cycle after acceptance, next request taken in the following cycle. Compute with two
// or more stamps: busy through the ring walk, the product step, one-bit divider steps
// over the 38-bit quotient and a finish step, or through the walk and the cut when no gap
// passes; the strobe comes in the cycle busy falls. Synchronous active-low reset restores the
// ring pointers, held speed and registers; the receiver cannot stall the strobe.
`default_nettype none

module tooth_period_rpm_meter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [47:0] i_now_us,
    output logic             o_strobe,
    output logic [31:0]      o_rpm_x256,
    output logic             o_edge_seen,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import tprm_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    cfg_we;

    // Configuration is taken only while idle and no request is being offered.
    assign o_cfg_ready = ~busy & ~start;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    tprm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .i_sts   (sts),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    tprm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_now_us    (i_now_us),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_strobe    (o_strobe),
        .o_rpm_x256  (o_rpm_x256),
        .o_edge_seen (o_edge_seen)
    );

endmodule

`default_nettype wire
